FILE: rtl/bmhq_pkg.sv
// Shared constants for the binary max heap queue.
// No dependencies; used by the top level and the testbench.
package bmhq_pkg;

  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 4;
  localparam int CAPACITY_DEF = 8;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

FILE: rtl/bmhq_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/binary_max_heap_queue.sv
// Binary max heap priority queue: sequencer, shared signed comparator, heap RAM.
// Depends on bmhq_pkg and bmhq_ram.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_ready   | in_operation, in_value
//   out     | output    | out_valid / out_ready | out_result_value, out_status, out_count
//
// One word at a time. Insert compares against each parent in turn (at most log2 CAPACITY of them).
// Extract: reads the root, then the last entry, then one or two children per level (one RAM read per child).
// Refused words go straight to the final state. Reads are serialized by the single RAM read port.
// Reset empties the heap at once; RAM contents are left as they are.
// A result waiting on out_ready holds the sequencer in its final state.
module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [bmhq_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bmhq_pkg::DATA_W-1:0] out_result_value,
  output logic [bmhq_pkg::STATUS_W-1:0]     out_status,
  output logic [bmhq_pkg::COUNT_W-1:0]      out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = AW + 2;
  localparam int DW = bmhq_pkg::DATA_W;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_UP_CMP  = 7'b0000010,
    ST_DN_ROOT = 7'b0000100,
    ST_DN_LAST = 7'b0001000,
    ST_DN_L    = 7'b0010000,
    ST_DN_R    = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [DW-1:0] best_r, best_nxt;
  logic best_left_r, best_left_nxt;
  logic [DW-1:0] res_r, res_nxt;
  logic [bmhq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic wr_flag_r, wr_flag_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_value_r;
  logic [bmhq_pkg::STATUS_W-1:0] out_status_r;
  logic [bmhq_pkg::COUNT_W-1:0] out_count_r;
  logic out_load;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic [DW-1:0] cmp_a, cmp_b;
  logic lt;
  logic [AW-1:0] up_src, up_par, up_gpar;
  logic [AW:0] dn_lc, dn_rc, desc_lc;
  logic [AW-1:0] desc_pos;
  logic desc_has, rc_has, fin_go;

  bmhq_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (state_r)
      ST_UP_CMP: begin
        cmp_a = ram_rdata;
        cmp_b = val_r;
      end
      ST_DN_L: begin
        cmp_a = val_r;
        cmp_b = ram_rdata;
      end
      ST_DN_R: begin
        cmp_a = best_r;
        cmp_b = ram_rdata;
      end
      default: begin
        cmp_a = val_r;
        cmp_b = ram_rdata;
      end
    endcase
  end

  assign lt = $signed(cmp_a) < $signed(cmp_b);

  assign up_src  = (state_r == ST_IDLE) ? count_r[AW-1:0] : pos_r;
  assign up_par  = AW'((up_src - AW'(1)) >> 1);
  assign up_gpar = AW'((up_par - AW'(1)) >> 1);

  assign dn_lc  = {pos_r, 1'b1};
  assign dn_rc  = dn_lc + (AW+1)'(1);
  assign rc_has = EW'(dn_rc) < EW'(count_r);

  always_comb begin
    case (state_r)
      ST_DN_L: desc_pos = dn_lc[AW-1:0];
      ST_DN_R: desc_pos = lt ? dn_rc[AW-1:0] : dn_lc[AW-1:0];
      default: desc_pos = '0;
    endcase
  end

  assign desc_lc  = {desc_pos, 1'b1};
  assign desc_has = EW'(desc_lc) < EW'(count_r);
  assign fin_go   = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    val_nxt       = val_r;
    best_nxt      = best_r;
    best_left_nxt = best_left_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    wr_flag_nxt   = wr_flag_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = '0;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt     = '0;
          status_nxt  = bmhq_pkg::STAT_OK;
          wr_flag_nxt = 1'b0;
          val_nxt     = in_value;
          if (in_operation == bmhq_pkg::OP_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = bmhq_pkg::STAT_FULL;
              state_nxt  = ST_FIN;
            end else begin
              count_nxt = count_r + CW'(1);
              pos_nxt   = count_r[AW-1:0];
              if (count_r == '0) begin
                wr_flag_nxt = 1'b1;
                state_nxt   = ST_FIN;
              end else begin
                ram_raddr = up_par;
                state_nxt = ST_UP_CMP;
              end
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = bmhq_pkg::STAT_EMPTY;
              state_nxt  = ST_FIN;
            end else begin
              count_nxt = count_r - CW'(1);
              ram_raddr = '0;
              state_nxt = ST_DN_ROOT;
            end
          end
        end
      end
      ST_UP_CMP: begin
        if (lt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = up_par;
          if (up_par == '0) begin
            wr_flag_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end else begin
            ram_raddr = up_gpar;
          end
        end else begin
          wr_flag_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_DN_ROOT: begin
        res_nxt   = ram_rdata;
        ram_raddr = count_r[AW-1:0];
        state_nxt = ST_DN_LAST;
      end
      ST_DN_LAST: begin
        val_nxt = ram_rdata;
        pos_nxt = '0;
        if (count_r == '0) begin
          state_nxt = ST_FIN;
        end else if (desc_has) begin
          ram_raddr = desc_lc[AW-1:0];
          state_nxt = ST_DN_L;
        end else begin
          wr_flag_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_DN_L: begin
        best_nxt      = lt ? ram_rdata : val_r;
        best_left_nxt = lt;
        if (rc_has) begin
          ram_raddr = dn_rc[AW-1:0];
          state_nxt = ST_DN_R;
        end else if (lt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = desc_pos;
          if (desc_has) begin
            ram_raddr = desc_lc[AW-1:0];
          end else begin
            wr_flag_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end
        end else begin
          wr_flag_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_DN_R: begin
        if (lt || best_left_r) begin
          ram_we    = 1'b1;
          ram_wdata = lt ? ram_rdata : best_r;
          pos_nxt   = desc_pos;
          if (desc_has) begin
            ram_raddr = desc_lc[AW-1:0];
            state_nxt = ST_DN_L;
          end else begin
            wr_flag_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end
        end else begin
          wr_flag_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          ram_we    = wr_flag_r;
          ram_wdata = val_r;
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    best_r      <= best_nxt;
    best_left_r <= best_left_nxt;
    res_r       <= res_nxt;
    status_r    <= status_nxt;
    wr_flag_r   <= wr_flag_nxt;
    if (out_load) begin
      out_value_r  <= res_r;
      out_status_r <= status_r;
      out_count_r  <= bmhq_pkg::COUNT_W'(count_r);
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_count        = out_count_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("heap count beyond capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && wr_flag_r) |-> (EW'(pos_r) < EW'(count_r)))
    else $error("final write outside the live heap");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UP_CMP) |-> (pos_r != '0))
    else $error("sift up compare at the root");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == bmhq_pkg::OP_INSERT &&
     count_r == CW'(CAPACITY))
    |=> (state_r == ST_FIN && status_r == bmhq_pkg::STAT_FULL &&
         count_r == $past(count_r)))
    else $error("full insert not refused");

endmodule

FILE: test/binary_max_heap_queue_test.sv
// Self-checking testbench for binary_max_heap_queue: directed and random heap traffic,
// predicted by a behavioral heap mirror and checked word by word on the result channel.
// Depends on bmhq_pkg and the binary_max_heap_queue RTL.
module binary_max_heap_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH = bmhq_pkg::CAPACITY_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic signed [bmhq_pkg::DATA_W-1:0] value;
    logic [bmhq_pkg::STATUS_W-1:0]      status;
    logic [bmhq_pkg::COUNT_W-1:0]       count;
  } heap_result_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic                                 in_operation;
  logic signed [bmhq_pkg::DATA_W-1:0]   in_value;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [bmhq_pkg::DATA_W-1:0]   out_result_value;
  logic [bmhq_pkg::STATUS_W-1:0]        out_status;
  logic [bmhq_pkg::COUNT_W-1:0]         out_count;

  logic signed [bmhq_pkg::DATA_W-1:0]   heap_mirror [HEAP_DEPTH];
  int                                   heap_fill;
  heap_result_t                         pending_results [$];
  int unsigned                          in_gap_max;
  int unsigned                          out_stall_max;
  int unsigned                          out_hold;
  int unsigned                          out_draw;
  int                                   mismatch_count;
  int                                   idle_cycles;

  binary_max_heap_queue #(.CAPACITY(HEAP_DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  always #5 clk = ~clk;

  // Mirror of the heap: applies one operation and returns the word it yields.
  function automatic heap_result_t heap_predict(
    input logic op,
    input logic signed [bmhq_pkg::DATA_W-1:0] val
  );
    heap_result_t                       r;
    int                                 pos;
    int                                 up;
    int                                 lc;
    int                                 rc;
    int                                 big;
    bit                                 done;
    logic signed [bmhq_pkg::DATA_W-1:0] t;
    r.value  = '0;
    r.status = bmhq_pkg::STAT_OK;
    if (op == bmhq_pkg::OP_INSERT) begin
      if (heap_fill >= HEAP_DEPTH) begin
        r.status = bmhq_pkg::STAT_FULL;
      end else begin
        heap_mirror[heap_fill] = val;
        pos  = heap_fill;
        done = 1'b0;
        while (!done && pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_mirror[up] < heap_mirror[pos]) begin
            t                = heap_mirror[up];
            heap_mirror[up]  = heap_mirror[pos];
            heap_mirror[pos] = t;
            pos              = up;
          end else begin
            done = 1'b1;
          end
        end
        heap_fill++;
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = bmhq_pkg::STAT_EMPTY;
      end else begin
        r.value = heap_mirror[0];
        heap_fill--;
        heap_mirror[0] = heap_mirror[heap_fill];
        pos  = 0;
        done = 1'b0;
        while (!done) begin
          lc  = 2 * pos + 1;
          rc  = lc + 1;
          big = pos;
          if (lc < heap_fill && heap_mirror[big] < heap_mirror[lc]) big = lc;
          if (rc < heap_fill && heap_mirror[big] < heap_mirror[rc]) big = rc;
          if (big == pos) begin
            done = 1'b1;
          end else begin
            t                = heap_mirror[big];
            heap_mirror[big] = heap_mirror[pos];
            heap_mirror[pos] = t;
            pos              = big;
          end
        end
      end
    end
    r.count = bmhq_pkg::COUNT_W'(heap_fill);
    return r;
  endfunction

  // Mostly full-range values, with extremes and a narrow band to force ties.
  function automatic logic signed [bmhq_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2, 3: return bmhq_pkg::DATA_W'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic issue_heap_op(input logic op,
                               input logic signed [bmhq_pkg::DATA_W-1:0] val);
    int unsigned gap;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(heap_predict(op, val));
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_extract_when_empty();
    issue_heap_op(bmhq_pkg::OP_EXTRACT, 32'sh7FFF_FFFF);
    issue_heap_op(bmhq_pkg::OP_EXTRACT, 32'sh0000_0000);
  endtask

  task automatic test_fill_to_capacity();
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sh8000_0000);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    issue_heap_op(bmhq_pkg::OP_INSERT, -32'sd1);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sh0000_0000);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sd5);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sd5);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sh8000_0000);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'sh5555_AAAA);
    issue_heap_op(bmhq_pkg::OP_INSERT, 32'shAAAA_5555);
  endtask

  task automatic test_drain_in_order();
    repeat (HEAP_DEPTH + 1) issue_heap_op(bmhq_pkg::OP_EXTRACT, $urandom);
  endtask

  // Bursts with a random insert bias walk the fill level between empty and full.
  task automatic test_random_traffic(input int unsigned items);
    int unsigned bias;
    logic        op;
    bias = 50;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(0, 2))
          0: bias = 20;
          1: bias = 50;
          default: bias = 80;
        endcase
      end
      op = ($urandom_range(0, 99) < bias) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_EXTRACT;
      issue_heap_op(op, random_value());
    end
  endtask

  task automatic test_random_back_to_back();
    in_gap_max    = 0;
    out_stall_max = 0;
    test_random_traffic(200);
  endtask

  task automatic test_random_with_gaps();
    in_gap_max    = 19;
    out_stall_max = 19;
    test_random_traffic(800);
  endtask

  // Result channel ready: after each accepted word, a random stall (possibly none) before ready returns.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_hold  <= 0;
      out_ready <= 1'b0;
    end else if (out_hold != 0) begin
      out_hold  <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else if (out_valid && out_ready) begin
      out_draw   = $urandom_range(0, out_stall_max);
      out_hold  <= out_draw;
      out_ready <= (out_draw == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    heap_result_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        exp_word = pending_results.pop_front();
        if (out_result_value !== exp_word.value)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    out_result_value, exp_word.value));
        if (out_status !== exp_word.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_status, exp_word.status));
        if (out_count !== exp_word.count)
          report_mismatch($sformatf("count %0d, expected %0d",
                                    out_count, exp_word.count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("binary_max_heap_queue_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= bmhq_pkg::OP_INSERT;
    in_value       <= '0;
    heap_fill      = 0;
    in_gap_max     = 19;
    out_stall_max  = 19;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extract_when_empty();
    test_fill_to_capacity();
    test_drain_in_order();
    test_random_back_to_back();
    test_random_with_gaps();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("binary_max_heap_queue_test: clean");
    end else begin
      $display("binary_max_heap_queue_test: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bmhq_pkg.sv
rtl/bmhq_ram.sv
rtl/binary_max_heap_queue.sv
test/binary_max_heap_queue_test.sv
